/* sv/gzbfs_pkg.sv */
// Package for the grid escape search block: cell kind codes, configuration
// register indexes and port widths.
// No dependencies.
`default_nettype none

package gzbfs_pkg;

  // Cell kinds as they arrive on the cell channel
  localparam logic [2:0] KIND_UP    = 3'd0;
  localparam logic [2:0] KIND_DOWN  = 3'd1;
  localparam logic [2:0] KIND_LEFT  = 3'd2;
  localparam logic [2:0] KIND_RIGHT = 3'd3;
  localparam logic [2:0] KIND_START = 3'd4;
  localparam logic [2:0] KIND_OTHER = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_BUDGET = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIM_W      = 8;
  localparam int unsigned BUDGET_W   = 16;

endpackage

`default_nettype wire

/* sv/gzbfs_cell_if.sv */
// Cell channel: one grid cell kind per beat, with the last-cell flag.
// Depends on nothing.
`default_nettype none

interface gzbfs_cell_if;
  logic       valid;
  logic       ready;
  logic [2:0] cell_kind;
  logic       last_cell;

  modport source (output valid, output cell_kind, output last_cell, input ready);
  modport sink   (input valid, input cell_kind, input last_cell, output ready);
endinterface

`default_nettype wire

/* sv/gzbfs_result_if.sv */
// Result channel: one escape verdict per beat.
// Depends on nothing.
`default_nettype none

interface gzbfs_result_if;
  logic valid;
  logic ready;
  logic escape_possible;

  modport source (output valid, output escape_possible, input ready);
  modport sink   (input valid, input escape_possible, output ready);
endinterface

`default_nettype wire

/* sv/grid_zero_one_bfs_escape_unit.sv */
// Grid escape unit: loads a grid cell by cell and runs a 0-1 BFS over it.
// Depends on gzbfs_pkg, gzbfs_cell_if and gzbfs_result_if.
//
// Usage
//   cell_i carries one cell kind per beat in row-major order; the beat with
//   last_cell set closes the grid and starts the search. result_o carries
//   one beat per grid: escape_possible. Configuration (rows, columns, cost
//   budget) is written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// Sequence
//   Loading takes each cell beat as it comes while in the load state. The
//   search starts with a bit-serial division of the start index by the
//   column count (one quotient bit per cycle) and a seed step, then each
//   deque pop runs the pop, pop-data, visited-read and visited-check states
//   and each neighbour runs the address, read and evaluate states; the steps
//   wait on the registered reads of the cell, visited and deque memories.
// Reset and stalls
//   Reset empties the deque, zeroes the start and load positions and sets
//   the registers to 128 rows, 128 columns and budget 0. The memories are
//   not cleared: each loaded cell clears its own visited bit. A result that
//   is not taken sits in the output register; cell beats keep loading the
//   next grid and search it; the new result waits for the output to drain.
`default_nettype none

module grid_zero_one_bfs_escape_unit
  import gzbfs_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = 128,
  parameter int unsigned MAX_COLS  = 128,
  parameter int unsigned COST_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  gzbfs_cell_if.sink                 cell_i,
  gzbfs_result_if.source             result_o
);

  localparam int unsigned CELL_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned IDX_W      = $clog2(CELL_DEPTH);
  localparam int unsigned LD_W       = $clog2(CELL_DEPTH + 1);
  localparam int unsigned RCW        = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW        = $clog2(MAX_COLS + 1);
  localparam int unsigned PW         = RCW + CCW + 1;
  localparam int unsigned DQ_DEPTH   = 4 * CELL_DEPTH;
  localparam int unsigned DQ_AW      = $clog2(DQ_DEPTH);
  localparam int unsigned DQ_CW      = $clog2(DQ_DEPTH + 1);
  localparam int unsigned DIVC_W     = $clog2(IDX_W + 1);
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  typedef struct packed {
    logic [RCW-1:0]       r;
    logic [CCW-1:0]       c;
    logic [COST_BITS-1:0] cost;
  } dq_entry_t;

  typedef enum logic [11:0] {
    S_LOAD  = 12'b0000_0000_0001,
    S_DIV   = 12'b0000_0000_0010,
    S_SEED  = 12'b0000_0000_0100,
    S_POP   = 12'b0000_0000_1000,
    S_POPD  = 12'b0000_0001_0000,
    S_VREAD = 12'b0000_0010_0000,
    S_VCHK  = 12'b0000_0100_0000,
    S_NADDR = 12'b0000_1000_0000,
    S_NREAD = 12'b0001_0000_0000,
    S_NEVAL = 12'b0010_0000_0000,
    S_DONE  = 12'b0100_0000_0000,
    S_SPARE = 12'b1000_0000_0000
  } state_e;

  // Configuration registers
  logic [DIM_W-1:0]    rows_cfg_q, cols_cfg_q;
  logic [BUDGET_W-1:0] budget_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= DIM_W'(128);
      cols_cfg_q <= DIM_W'(128);
      budget_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_ROWS:   rows_cfg_q <= cfg_data_i[DIM_W-1:0];
        CFG_GRID_COLS:   cols_cfg_q <= cfg_data_i[DIM_W-1:0];
        CFG_COST_BUDGET: budget_q   <= cfg_data_i[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped grid dimensions
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;

  always_comb begin
    if (rows_cfg_q == '0)                 rows_eff = RCW'(1);
    else if (32'(rows_cfg_q) > MAX_ROWS)  rows_eff = RCW'(MAX_ROWS);
    else                                  rows_eff = RCW'(rows_cfg_q);
    if (cols_cfg_q == '0)                 cols_eff = CCW'(1);
    else if (32'(cols_cfg_q) > MAX_COLS)  cols_eff = CCW'(MAX_COLS);
    else                                  cols_eff = CCW'(cols_cfg_q);
  end

  // Control registers
  state_e               state_q;
  logic [LD_W-1:0]      load_cnt_q;
  logic [IDX_W-1:0]     start_q;
  logic [IDX_W-1:0]     div_num_q;
  logic [CCW-1:0]       div_rem_q;
  logic [DIVC_W-1:0]    div_cnt_q;
  logic [DQ_AW-1:0]     head_q;
  logic [DQ_CW-1:0]     count_q;
  logic                 first_q;
  dq_entry_t            cur_q;
  logic [IDX_W-1:0]     p_q, np_q;
  logic [1:0]           dir_q;
  logic                 res_q;
  logic                 out_valid_q, out_bit_q;

  // Memory read data
  logic [2:0]           kind_rd_q;
  logic                 vis_rd_q;
  dq_entry_t            dq_rd_q;

  logic cell_acc;
  assign cell_i.ready = (state_q == S_LOAD);
  assign cell_acc     = cell_i.valid && cell_i.ready;
  assign result_o.valid           = out_valid_q;
  assign result_o.escape_possible = out_bit_q;

  // Division step: one quotient bit per cycle
  logic [CCW:0]   div_trial;
  logic           div_bit;
  logic [CCW-1:0] div_rem_d;
  always_comb begin
    div_trial = {div_rem_q, div_num_q[IDX_W-1]};
    div_bit   = (div_trial >= {1'b0, cols_eff});
    div_rem_d = div_bit ? CCW'(div_trial - {1'b0, cols_eff}) : CCW'(div_trial);
  end

  // Neighbour for the current direction
  logic [RCW-1:0] nr;
  logic [CCW-1:0] nc;
  logic [2:0]     k_against, k_along, k_nb;
  logic [COST_BITS-1:0] cost_inc;
  always_comb begin
    nr = cur_q.r;
    nc = cur_q.c;
    unique case (dir_q)
      2'd0: begin nr = cur_q.r + RCW'(1); k_against = KIND_UP;    k_along = KIND_DOWN;  end
      2'd1: begin nr = cur_q.r - RCW'(1); k_against = KIND_DOWN;  k_along = KIND_UP;    end
      2'd2: begin nc = cur_q.c + CCW'(1); k_against = KIND_LEFT;  k_along = KIND_RIGHT; end
      default: begin
        nc = cur_q.c - CCW'(1); k_against = KIND_RIGHT; k_along = KIND_LEFT;
      end
    endcase
    k_nb     = ({1'b0, np_q} < (IDX_W+1)'(load_cnt_q)) ? kind_rd_q : KIND_OTHER;
    cost_inc = (cur_q.cost == COST_MAX) ? COST_MAX : cur_q.cost + COST_BITS'(1);
  end

  // Linear index of the popped cell and of the neighbour
  logic [PW-1:0] p_lin, np_lin;
  assign p_lin  = PW'(dq_rd_q.r * cols_eff) + PW'(dq_rd_q.c);
  assign np_lin = PW'(nr * cols_eff) + PW'(nc);

  // Deque pointer arithmetic
  logic [DQ_AW-1:0] head_dec, head_inc, tail_slot;
  logic [DQ_AW:0]   tail_sum;
  logic             dq_full;
  always_comb begin
    head_dec = (head_q == '0) ? DQ_AW'(DQ_DEPTH - 1) : head_q - DQ_AW'(1);
    head_inc = (32'(head_q) == DQ_DEPTH - 1) ? '0 : head_q + DQ_AW'(1);
    tail_sum = (DQ_AW+1)'(head_q) + (DQ_AW+1)'(count_q);
    tail_slot = (32'(tail_sum) >= DQ_DEPTH) ? DQ_AW'(tail_sum - (DQ_AW+1)'(DQ_DEPTH))
                                            : DQ_AW'(tail_sum);
    dq_full  = (32'(count_q) >= DQ_DEPTH);
  end

  logic border;
  assign border = (cur_q.r == '0) || (cur_q.c == '0) ||
                  (cur_q.r == rows_eff - RCW'(1)) || (cur_q.c == cols_eff - CCW'(1));

  // Memory write controls
  logic             dq_we;
  logic [DQ_AW-1:0] dq_waddr;
  dq_entry_t        dq_wdata;
  logic             dq_add_head, dq_add_tail;
  always_comb begin
    dq_add_head = 1'b0;
    dq_add_tail = 1'b0;
    if (state_q == S_NEVAL && !vis_rd_q && !dq_full) begin
      if (k_nb == k_against)     dq_add_head = 1'b1;
      else if (k_nb == k_along)  dq_add_tail = 1'b1;
    end
    dq_we    = dq_add_head || dq_add_tail || (state_q == S_SEED);
    dq_waddr = dq_add_tail ? tail_slot : head_dec;
    dq_wdata.r    = nr;
    dq_wdata.c    = nc;
    dq_wdata.cost = dq_add_tail ? cost_inc : cur_q.cost;
    if (state_q == S_SEED) begin
      dq_waddr      = DQ_AW'(DQ_DEPTH - 1);
      dq_wdata.r    = RCW'(div_num_q);
      dq_wdata.c    = div_rem_q;
      dq_wdata.cost = '0;
    end
  end

  logic             ld_we;
  logic [IDX_W-1:0] ld_addr;
  assign ld_we   = cell_acc && (32'(load_cnt_q) < CELL_DEPTH);
  assign ld_addr = IDX_W'(load_cnt_q);

  // Memories: cell kinds, visited marks and the search deque
  logic [2:0]  kind_mem [CELL_DEPTH];
  logic        vis_mem  [CELL_DEPTH];
  dq_entry_t   dq_mem   [DQ_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      kind_mem[ld_addr] <= (cell_i.cell_kind > KIND_OTHER) ? KIND_OTHER : cell_i.cell_kind;
    end
    kind_rd_q <= kind_mem[np_q];
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      vis_mem[ld_addr] <= 1'b0;
    end else if (state_q == S_VCHK) begin
      vis_mem[p_q] <= 1'b1;
    end
    vis_rd_q <= vis_mem[(state_q == S_VREAD) ? p_q : np_q];
  end

  always_ff @(posedge clk_i) begin
    if (dq_we) begin
      dq_mem[dq_waddr] <= dq_wdata;
    end
    dq_rd_q <= dq_mem[head_q];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      load_cnt_q  <= '0;
      start_q     <= '0;
      div_num_q   <= '0;
      div_rem_q   <= '0;
      div_cnt_q   <= '0;
      head_q      <= '0;
      count_q     <= '0;
      first_q     <= 1'b0;
      dir_q       <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_bit_q   <= 1'b0;
      cur_q       <= '0;
      p_q         <= '0;
      np_q        <= '0;
    end else begin
      // the done step refills the output itself
      if (out_valid_q && result_o.ready && state_q != S_DONE) out_valid_q <= 1'b0;
      if (dq_add_head) begin
        head_q  <= head_dec;
        count_q <= count_q + DQ_CW'(1);
      end else if (dq_add_tail) begin
        count_q <= count_q + DQ_CW'(1);
      end
      unique case (state_q)
        S_LOAD: begin
          if (cell_acc) begin
            if (ld_we) begin
              if (cell_i.cell_kind == KIND_START) start_q <= ld_addr;
              load_cnt_q <= load_cnt_q + LD_W'(1);
            end
            if (cell_i.last_cell) begin
              div_num_q <= (ld_we && cell_i.cell_kind == KIND_START) ? ld_addr : start_q;
              div_rem_q <= '0;
              div_cnt_q <= '0;
              state_q   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          div_num_q <= {div_num_q[IDX_W-2:0], div_bit};
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q + DIVC_W'(1);
          if (32'(div_cnt_q) == IDX_W - 1) state_q <= S_SEED;
        end
        S_SEED: begin
          if ((IDX_W+RCW)'(div_num_q) >= (IDX_W+RCW)'(rows_eff)) begin
            res_q   <= 1'b0;
            state_q <= S_DONE;
          end else begin
            head_q  <= DQ_AW'(DQ_DEPTH - 1);
            count_q <= DQ_CW'(1);
            first_q <= 1'b1;
            state_q <= S_POP;
          end
        end
        S_POP: begin
          if (count_q == '0) begin
            res_q   <= 1'b0;
            state_q <= S_DONE;
          end else begin
            head_q  <= head_inc;
            count_q <= count_q - DQ_CW'(1);
            state_q <= S_POPD;
          end
        end
        S_POPD: begin
          cur_q <= dq_rd_q;
          p_q   <= IDX_W'(p_lin);
          if (32'(dq_rd_q.cost) > 32'(budget_q)) begin
            res_q   <= 1'b0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_VREAD;
          end
        end
        S_VREAD: state_q <= S_VCHK;
        S_VCHK: begin
          first_q <= 1'b0;
          if (vis_rd_q && !first_q) begin
            state_q <= S_POP;
          end else if (border) begin
            res_q   <= 1'b1;
            state_q <= S_DONE;
          end else begin
            dir_q   <= '0;
            state_q <= S_NADDR;
          end
        end
        S_NADDR: begin
          np_q    <= IDX_W'(np_lin);
          state_q <= S_NREAD;
        end
        S_NREAD: state_q <= S_NEVAL;
        S_NEVAL: begin
          dir_q   <= dir_q + 2'd1;
          state_q <= (dir_q == 2'd3) ? S_POP : S_NADDR;
        end
        S_DONE: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q <= 1'b1;
            out_bit_q   <= res_q;
            load_cnt_q  <= '0;
            state_q     <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");
  a_dq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DQ_DEPTH) else $error("deque count beyond depth");
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(load_cnt_q) <= CELL_DEPTH) else $error("load position beyond store");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done step");
`endif

endmodule

`default_nettype wire

/* tb/grid_zero_one_bfs_escape_unit_test.sv */
// Testbench for grid_zero_one_bfs_escape_unit: streams grids of cell kinds,
// predicts each escape verdict with a 0-1 BFS of its own and checks results.
// Depends on gzbfs_pkg, gzbfs_cell_if, gzbfs_result_if and the unit itself.
`default_nettype none

module grid_zero_one_bfs_escape_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gzbfs_pkg::*;

  localparam int unsigned GRID_MAX   = 128;
  localparam int unsigned CELL_SLOTS = GRID_MAX * GRID_MAX;
  localparam int unsigned DQ_SLOTS   = 4 * CELL_SLOTS;
  localparam int unsigned COST_TOP   = 65535;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned IDLE_LIMIT = 1500000;
  localparam int unsigned RANDOM_ITEMS = 1250;

  // Grid store plus 0-1 BFS that gives the verdict for each closed grid
  class escape_predictor;
    logic [2:0]  cells[CELL_SLOTS];
    bit          seen[CELL_SLOTS];
    int unsigned dq_pos[DQ_SLOTS];
    int unsigned dq_cost[DQ_SLOTS];
    int unsigned dq_head;
    int unsigned dq_count;
    int unsigned load_pos;
    int unsigned start_pos;
    int unsigned rows_reg;
    int unsigned cols_reg;
    int unsigned budget_reg;
    bit          verdicts[$];
    int unsigned errors;

    function void reset_state();
      load_pos   = 0;
      start_pos  = 0;
      rows_reg   = 128;
      cols_reg   = 128;
      budget_reg = 0;
      dq_head    = 0;
      dq_count   = 0;
      verdicts.delete();
      errors     = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_ROWS:   rows_reg = data[7:0];
        CFG_GRID_COLS:   cols_reg = data[7:0];
        CFG_COST_BUDGET: budget_reg = data;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      return (v > GRID_MAX) ? GRID_MAX : v;
    endfunction

    function logic [2:0] kind_at(int unsigned idx);
      if (idx >= load_pos || idx >= CELL_SLOTS) return KIND_OTHER;
      return cells[idx];
    endfunction

    // Ring deque: entry at the head or at the tail
    function void dq_put_head(int unsigned pos, int unsigned cost);
      if (dq_count >= DQ_SLOTS) return;
      dq_head = (dq_head + DQ_SLOTS - 1) % DQ_SLOTS;
      dq_pos[dq_head]  = pos;
      dq_cost[dq_head] = cost;
      dq_count++;
    endfunction

    function void dq_put_tail(int unsigned pos, int unsigned cost);
      int unsigned slot;
      if (dq_count >= DQ_SLOTS) return;
      slot = (dq_head + dq_count) % DQ_SLOTS;
      dq_pos[slot]  = pos;
      dq_cost[slot] = cost;
      dq_count++;
    endfunction

    function bit search_escape();
      int unsigned rows, cols, total, r, c, nr, nc, np, pos, cost;
      logic [2:0]  k, against, along;
      rows  = clamp_dim(rows_reg);
      cols  = clamp_dim(cols_reg);
      total = rows * cols;
      if (start_pos >= total) return 1'b0;
      foreach (seen[i]) seen[i] = 1'b0;
      dq_head  = 0;
      dq_count = 0;
      dq_put_head(start_pos, 0);
      while (dq_count > 0) begin
        pos     = dq_pos[dq_head];
        cost    = dq_cost[dq_head];
        dq_head = (dq_head + 1) % DQ_SLOTS;
        dq_count--;
        if (cost > budget_reg) break;
        if (pos >= total || seen[pos]) continue;
        seen[pos] = 1'b1;
        r = pos / cols;
        c = pos % cols;
        if (r == 0 || c == 0 || r == rows - 1 || c == cols - 1) return 1'b1;
        for (int d = 0; d < 4; d++) begin
          nr = r;
          nc = c;
          case (d)
            0: begin nr = r + 1; against = KIND_UP;    along = KIND_DOWN;  end
            1: begin nr = r - 1; against = KIND_DOWN;  along = KIND_UP;    end
            2: begin nc = c + 1; against = KIND_LEFT;  along = KIND_RIGHT; end
            default: begin nc = c - 1; against = KIND_RIGHT; along = KIND_LEFT; end
          endcase
          np = nr * cols + nc;
          if (seen[np]) continue;
          k = kind_at(np);
          if (k == against) dq_put_head(np, cost);
          else if (k == along)
            dq_put_tail(np, (cost >= COST_TOP) ? COST_TOP : cost + 1);
        end
      end
      return 1'b0;
    endfunction

    // Accepted cell beat: store it, and on the last cell predict a verdict
    function void note_cell(logic [2:0] kind, logic last);
      if (load_pos < CELL_SLOTS) begin
        cells[load_pos] = (kind > KIND_OTHER) ? KIND_OTHER : kind;
        if (kind == KIND_START) start_pos = load_pos;
        load_pos++;
      end
      if (last) begin
        verdicts.insert(verdicts.size(), search_escape());
        load_pos = 0;
      end
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (verdicts.size() == 0) begin
        $error("escape_possible: unexpected result beat, actual %0b", got);
        errors++;
        return;
      end
      want = verdicts[0];
      verdicts.delete(0);
      if (got !== want) begin
        $error("escape_possible: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gzbfs_cell_if   cell_ch ();
  gzbfs_result_if res_ch ();

  grid_zero_one_bfs_escape_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cell_i     (cell_ch),
    .result_o   (res_ch)
  );

  escape_predictor pred = new();
  int unsigned tx_gap_max = 0;
  int unsigned rx_gap_max = 0;
  int unsigned idle_cycles = 0;
  int unsigned random_items = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    cell_ch.valid     = 1'b0;
    cell_ch.cell_kind = KIND_OTHER;
    cell_ch.last_cell = 1'b0;
    res_ch.ready      = 1'b0;
  end

  // Monitors: predict on accepted cells, check accepted verdicts
  always @(posedge clk_i) begin
    if (rst_ni && cell_ch.valid && cell_ch.ready)
      pred.note_cell(cell_ch.cell_kind, cell_ch.last_cell);
    if (rst_ni && res_ch.valid && res_ch.ready)
      pred.check_verdict(res_ch.escape_possible);
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((cell_ch.valid && cell_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("grid_zero_one_bfs_escape_unit test failed");
      $finish;
    end
  end

  // Result side: random stall before each beat
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
    end
  end

  task automatic send_cell(logic [2:0] kind, logic last);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_ch.valid     <= 1'b1;
    cell_ch.cell_kind <= kind;
    cell_ch.last_cell <= last;
    @(posedge clk_i);
    while (!cell_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_grid(logic [2:0] grid[$]);
    foreach (grid[i]) send_cell(grid[i], i == grid.size() - 1);
    cell_ch.valid <= 1'b0;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    pred.note_config(idx, data);
  endtask

  // Wait for every verdict, then let the unit settle before reconfiguring;
  // the first edge lets the monitor note the last cell beat
  task automatic drain();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    while (pred.verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_dims(int unsigned rows, int unsigned cols, int unsigned budget);
    drain();
    cfg_write(CFG_GRID_ROWS, {8'($urandom_range(0, 255)), 8'(rows)});
    cfg_write(CFG_GRID_COLS, {8'($urandom_range(0, 255)), 8'(cols)});
    cfg_write(CFG_COST_BUDGET, 16'(budget));
    cfg_we_i <= 1'b0;
  endtask

  // Random grid: mostly arrows, usually one start mark, length mostly exact
  function automatic void make_grid(int unsigned total, output logic [2:0] grid[$]);
    int unsigned len, sel;
    grid.delete();
    sel = $urandom_range(0, 9);
    if (sel == 0) len = $urandom_range(1, total);
    else if (sel == 1) len = total + $urandom_range(1, 3);
    else len = total;
    for (int unsigned i = 0; i < len; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 16) grid.insert(grid.size(), 3'($urandom_range(KIND_UP, KIND_RIGHT)));
      else if (sel == 16) grid.insert(grid.size(), KIND_START);
      else grid.insert(grid.size(), 3'($urandom_range(KIND_OTHER, 7)));
    end
    sel = $urandom_range(0, 19);
    if (sel < 17) grid[$urandom_range(0, len - 1)] = KIND_START;
    if (sel > 14) grid[$urandom_range(0, len - 1)] = KIND_START;
  endfunction

  initial begin
    logic [2:0]  grid[$];
    int unsigned rows, cols, budget;
    pred.reset_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: walls, border start, arrow costs, odd kinds, odd sizes
    set_dims(3, 3, 0);
    cfg_write(CFG_SPARE, 16'hFFFF);
    cfg_we_i <= 1'b0;
    send_grid('{KIND_OTHER, KIND_OTHER, KIND_OTHER, KIND_OTHER, KIND_START,
                KIND_OTHER, 3'd6, 3'd7, KIND_OTHER});
    send_grid('{KIND_START, KIND_UP, KIND_DOWN, KIND_LEFT, KIND_RIGHT,
                KIND_OTHER, KIND_UP, KIND_UP, KIND_UP});
    // up arrow above: along the move, costs one
    send_grid('{KIND_OTHER, KIND_UP, KIND_OTHER, KIND_OTHER, KIND_START,
                KIND_OTHER, KIND_OTHER, KIND_OTHER, KIND_OTHER});
    set_dims(3, 3, 1);
    send_grid('{KIND_OTHER, KIND_UP, KIND_OTHER, KIND_OTHER, KIND_START,
                KIND_OTHER, KIND_OTHER, KIND_OTHER, KIND_OTHER});
    // left arrow to the right: against the move, free; last cell came early
    set_dims(3, 3, 0);
    send_grid('{KIND_OTHER, KIND_OTHER, KIND_OTHER, KIND_OTHER, KIND_START,
                KIND_LEFT});
    // two start marks, no start mark, start outside a smaller grid
    send_grid('{KIND_START, KIND_OTHER, KIND_OTHER, KIND_OTHER, KIND_START});
    send_grid('{KIND_OTHER, KIND_OTHER, KIND_RIGHT});
    set_dims(0, 2, 65535);
    send_grid('{KIND_OTHER, KIND_OTHER});
    set_dims(200, 1, 65535);
    send_grid('{KIND_START});
    set_dims(1, 255, 3);
    send_grid('{KIND_UP, KIND_START});

    // Random phases of grids
    while (random_items < RANDOM_ITEMS) begin
      rows = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9);
      cols = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: budget = $urandom_range(0, 4);
        5, 6, 7:       budget = $urandom_range(5, 40);
        8:             budget = 65535;
        default:       budget = $urandom_range(0, 65535);
      endcase
      set_dims(rows, cols, budget);
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      repeat ($urandom_range(1, 6)) begin
        make_grid(pred.clamp_dim(rows) * pred.clamp_dim(cols), grid);
        random_items += grid.size();
        send_grid(grid);
      end
    end

    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    while (pred.verdicts.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (pred.errors == 0)
      $display("grid_zero_one_bfs_escape_unit test passed");
    else
      $display("grid_zero_one_bfs_escape_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/gzbfs_pkg.sv
sv/gzbfs_cell_if.sv
sv/gzbfs_result_if.sv
sv/grid_zero_one_bfs_escape_unit.sv
tb/grid_zero_one_bfs_escape_unit_test.sv
